// ===== src/mcmr_pkg.sv =====
// ----------------------------------------------------------------------------
// MIDI channel message router package
// Shared types, register indexes, reset values and message codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mcmr_pkg;

  localparam int NumChannels   = 16;
  localparam int RoutingW      = 51;
  localparam int CfgDataW      = 64;
  localparam int CfgAddrW      = 6;
  localparam int JobQueueDepth = 2;

  // Register indexes, at byte address 8 * index.
  localparam logic [2:0] RegRouting    = 3'd0;
  localparam logic [2:0] RegRemap      = 3'd1;
  localparam logic [2:0] RegAllowALow  = 3'd2;
  localparam logic [2:0] RegAllowAHigh = 3'd3;
  localparam logic [2:0] RegAllowBLow  = 3'd4;
  localparam logic [2:0] RegAllowBHigh = 3'd5;
  localparam logic [2:0] RegVolLow     = 3'd6;
  localparam logic [2:0] RegVolHigh    = 3'd7;

  localparam logic [RoutingW-1:0] RoutingReset = '0;
  localparam logic [63:0] RemapReset = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] AllowReset = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VolReset   = 64'h8080_8080_8080_8080;

  // Target engines.
  localparam logic [1:0] EngA = 2'd0;
  localparam logic [1:0] EngB = 2'd1;
  localparam logic [1:0] EngC = 2'd2;

  // Channel routing codes.
  localparam logic [1:0] RouteNone = 2'd0;
  localparam logic [1:0] RouteA    = 2'd1;
  localparam logic [1:0] RouteB    = 2'd2;

  // Message types (upper nibble of the status byte).
  localparam logic [3:0] MsgSystem     = 4'hF;
  localparam logic [3:0] MsgCtrlChange = 4'hB;
  localparam logic [3:0] MsgNoteOn     = 4'h9;
  localparam logic [3:0] MsgNoteOff    = 4'h8;

  localparam logic [6:0] CcVolume  = 7'd7;
  localparam logic [14:0] RoundHalf = 15'd64;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_one;
    logic [7:0] data_two;
  } in_item_t;

  typedef struct packed {
    logic [1:0] target_engine;
    logic [7:0] out_status;
    logic [7:0] out_data_one;
    logic [7:0] out_data_two;
    logic       last_delivery;
  } out_item_t;

  typedef struct packed {
    logic [RoutingW-1:0] routing;
    logic [63:0]         remap;
    logic [63:0]         allow_a_lo;
    logic [63:0]         allow_a_hi;
    logic [63:0]         allow_b_lo;
    logic [63:0]         allow_b_hi;
    logic [63:0]         vol_lo;
    logic [63:0]         vol_hi;
  } cfg_t;

  // One classified message: one or two deliveries sharing the same bytes.
  typedef struct packed {
    logic [1:0] eng_first;
    logic [1:0] eng_second;
    logic       two;
    logic [7:0] status;
    logic [7:0] data_one;
    logic [7:0] data_two;
  } job_t;

endpackage

`default_nettype wire

// ===== src/mcmr_cfg.sv =====
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding routing, remap, allow masks and volumes.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmr_cfg (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [mcmr_pkg::CfgAddrW-1:0]   paddr,
  input  wire logic [mcmr_pkg::CfgDataW-1:0]   pwdata,
  output      logic [mcmr_pkg::CfgDataW-1:0]   prdata,
  output      logic                            pready,
  output      mcmr_pkg::cfg_t                  cfg_o
);

  mcmr_pkg::cfg_t cfg_q, cfg_d;
  logic [2:0]     reg_idx;
  logic           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[mcmr_pkg::CfgAddrW-1:3];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        mcmr_pkg::RegRouting:    cfg_d.routing    = pwdata[mcmr_pkg::RoutingW-1:0];
        mcmr_pkg::RegRemap:      cfg_d.remap      = pwdata;
        mcmr_pkg::RegAllowALow:  cfg_d.allow_a_lo = pwdata;
        mcmr_pkg::RegAllowAHigh: cfg_d.allow_a_hi = pwdata;
        mcmr_pkg::RegAllowBLow:  cfg_d.allow_b_lo = pwdata;
        mcmr_pkg::RegAllowBHigh: cfg_d.allow_b_hi = pwdata;
        mcmr_pkg::RegVolLow:     cfg_d.vol_lo     = pwdata;
        mcmr_pkg::RegVolHigh:    cfg_d.vol_hi     = pwdata;
        default:                 cfg_d            = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      mcmr_pkg::RegRouting:    prdata = {{(mcmr_pkg::CfgDataW - mcmr_pkg::RoutingW){1'b0}},
                                         cfg_q.routing};
      mcmr_pkg::RegRemap:      prdata = cfg_q.remap;
      mcmr_pkg::RegAllowALow:  prdata = cfg_q.allow_a_lo;
      mcmr_pkg::RegAllowAHigh: prdata = cfg_q.allow_a_hi;
      mcmr_pkg::RegAllowBLow:  prdata = cfg_q.allow_b_lo;
      mcmr_pkg::RegAllowBHigh: prdata = cfg_q.allow_b_hi;
      mcmr_pkg::RegVolLow:     prdata = cfg_q.vol_lo;
      mcmr_pkg::RegVolHigh:    prdata = cfg_q.vol_hi;
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.routing    <= mcmr_pkg::RoutingReset;
      cfg_q.remap      <= mcmr_pkg::RemapReset;
      cfg_q.allow_a_lo <= mcmr_pkg::AllowReset;
      cfg_q.allow_a_hi <= mcmr_pkg::AllowReset;
      cfg_q.allow_b_lo <= mcmr_pkg::AllowReset;
      cfg_q.allow_b_hi <= mcmr_pkg::AllowReset;
      cfg_q.vol_lo     <= mcmr_pkg::VolReset;
      cfg_q.vol_hi     <= mcmr_pkg::VolReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/mcmr_front.sv =====
// ----------------------------------------------------------------------------
// Message classifier
// Decides which engines get a message and prepares the outgoing bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmr_front (
  input  wire mcmr_pkg::cfg_t     cfg_i,
  input  wire mcmr_pkg::in_item_t item_i,
  output      mcmr_pkg::job_t     job_o,
  output      logic               has_work_o
);

  logic [3:0]  ch;
  logic [3:0]  msg_type;
  logic [1:0]  code;
  logic        layered;
  logic [3:0]  present;
  logic [1:0]  own_eng;
  logic        own_present;
  logic [6:0]  cc;
  logic        allow_a;
  logic        allow_b;
  logic        own_allow;
  logic [63:0] vol_word;
  logic [7:0]  vol;
  logic [14:0] scaled;
  logic [7:0]  cc_data_two;
  logic [7:0]  remapped;
  logic [2:0]  cand_v;
  logic [1:0]  cand_e [3];
  logic [7:0]  status_out;
  logic [7:0]  data_two_out;
  logic [1:0]  eng_first;
  logic [1:0]  eng_second;
  logic        two;

  assign ch       = item_i.status_byte[3:0];
  assign msg_type = item_i.status_byte[7:4];
  assign code     = cfg_i.routing[{ch, 1'b0} +: 2];
  assign layered  = cfg_i.routing[32 + int'(ch)];
  // Bit 3 pads the lookup so that the unused engine code reads as absent.
  assign present  = {1'b0, cfg_i.routing[mcmr_pkg::RoutingW-1 -: 3]};
  assign own_eng  = code - 2'd1;
  assign own_present = present[own_eng];
  assign remapped = {msg_type, cfg_i.remap[{ch, 2'b00} +: 4]};

  assign cc      = item_i.data_one[6:0];
  assign allow_a = cc[6] ? cfg_i.allow_a_hi[cc[5:0]] : cfg_i.allow_a_lo[cc[5:0]];
  assign allow_b = cc[6] ? cfg_i.allow_b_hi[cc[5:0]] : cfg_i.allow_b_lo[cc[5:0]];
  assign own_allow = (own_eng == mcmr_pkg::EngA) ? allow_a : allow_b;

  // Volume is Q1.7; only values below unity scale, with round to nearest.
  assign vol_word = ch[3] ? cfg_i.vol_hi : cfg_i.vol_lo;
  assign vol      = vol_word[{ch[2:0], 3'b000} +: 8];
  assign scaled   = 15'(item_i.data_two[6:0]) * 15'(vol) + mcmr_pkg::RoundHalf;
  assign cc_data_two = (cc == mcmr_pkg::CcVolume && !vol[7]) ? scaled[14:7]
                                                             : item_i.data_two;

  always_comb begin
    cand_v       = '0;
    cand_e[0]    = mcmr_pkg::EngA;
    cand_e[1]    = mcmr_pkg::EngB;
    cand_e[2]    = mcmr_pkg::EngB;
    status_out   = remapped;
    data_two_out = item_i.data_two;
    if (msg_type == mcmr_pkg::MsgSystem) begin
      cand_v[0]  = present[0];
      cand_v[1]  = present[1];
      status_out = item_i.status_byte;
    end else if (msg_type == mcmr_pkg::MsgCtrlChange) begin
      // Own engine first, then the layered copies to A and B.
      cand_v[0] = (code == mcmr_pkg::RouteA || code == mcmr_pkg::RouteB) &&
                  own_present && own_allow;
      cand_e[0] = own_eng;
      cand_v[1] = layered && code != mcmr_pkg::RouteA && present[0] && allow_a;
      cand_e[1] = mcmr_pkg::EngA;
      cand_v[2] = layered && code != mcmr_pkg::RouteB && present[1] && allow_b;
      cand_e[2] = mcmr_pkg::EngB;
      data_two_out = cc_data_two;
    end else if (layered && (msg_type == mcmr_pkg::MsgNoteOn ||
                             msg_type == mcmr_pkg::MsgNoteOff)) begin
      cand_v[0] = present[0];
      cand_v[1] = present[1];
    end else begin
      cand_v[0] = (code != mcmr_pkg::RouteNone) && own_present;
      cand_e[0] = own_eng;
    end
  end

  // At most two candidates are ever valid; keep the first two in order.
  always_comb begin
    eng_first  = cand_e[0];
    eng_second = cand_e[1];
    two        = 1'b0;
    if (cand_v[0]) begin
      two        = cand_v[1] || cand_v[2];
      eng_second = cand_v[1] ? cand_e[1] : cand_e[2];
    end else if (cand_v[1]) begin
      eng_first  = cand_e[1];
      eng_second = cand_e[2];
      two        = cand_v[2];
    end else begin
      eng_first  = cand_e[2];
    end
  end

  assign job_o = '{eng_first:  eng_first,
                   eng_second: eng_second,
                   two:        two,
                   status:     status_out,
                   data_one:   item_i.data_one,
                   data_two:   data_two_out};

  assign has_work_o = |cand_v;

endmodule

`default_nettype wire

// ===== src/mcmr_job_fifo.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Short queue of classified messages between the classifier and the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmr_job_fifo #(
  parameter int Depth = mcmr_pkg::JobQueueDepth
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire mcmr_pkg::job_t data_i,
  output      logic           full_o,
  input  wire logic           pop_i,
  output      logic           valid_o,
  output      mcmr_pkg::job_t head_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  mcmr_pkg::job_t  entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/mcmr_back.sv =====
// ----------------------------------------------------------------------------
// Delivery sender
// Expands each queued message into its deliveries, one per cycle while the
// receiver pops, into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                job_valid_i,
  input  wire mcmr_pkg::job_t      job_i,
  output      logic                job_pop_o,
  input  wire logic                pop,
  output      logic                out_valid_o,
  output      mcmr_pkg::out_item_t out_item_o
);

  logic                out_valid_q, out_valid_d;
  mcmr_pkg::out_item_t out_q, out_d;
  logic                second_q, second_d;
  logic                load;
  logic                last;

  // The result register can take a new delivery when empty or being drained.
  assign load = !out_valid_q || pop;
  assign last = second_q || !job_i.two;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    second_d    = second_q;
    job_pop_o   = 1'b0;
    if (load && job_valid_i) begin
      out_valid_d         = 1'b1;
      out_d.target_engine = second_q ? job_i.eng_second : job_i.eng_first;
      out_d.out_status    = job_i.status;
      out_d.out_data_one  = job_i.data_one;
      out_d.out_data_two  = job_i.data_two;
      out_d.last_delivery = last;
      second_d            = !last;
      job_pop_o           = last;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      second_q    <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

`default_nettype wire

// ===== src/midi_channel_message_router.sv =====
// ----------------------------------------------------------------------------
// MIDI channel message router
// Routes three-byte MIDI short messages to up to two synthesis engines.
// ----------------------------------------------------------------------------
// Usage:
//   Messages enter through a queue-style port (push/full). Each causes zero
//   to two deliveries, which leave through a queue-style port (empty/pop),
//   oldest first; last_delivery marks the final delivery of a message.
//   A message that causes no delivery is absorbed in its accepting cycle.
//   The first delivery of a message passes through the job queue and then
//   the result register before it reaches the result ports.
//   Throughput: the sender moves one delivery per cycle while the receiver
//   pops; each delivery of a message is one move. The classifier takes a
//   message every cycle while the job queue has room.
//   When the receiver stalls, the result register holds its delivery, the
//   job queue fills, and full rises.
//   Reset empties the job queue and the result register and loads the
//   register defaults. The user writes configuration through the APB-style
//   port (8-byte stride) only while no message is in flight (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module midi_channel_message_router #(
  parameter int JobQueueDepth = mcmr_pkg::JobQueueDepth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output      logic                          full,
  input  wire mcmr_pkg::in_item_t            in_item_i,
  output      logic                          empty,
  input  wire logic                          pop,
  output      mcmr_pkg::out_item_t           out_item_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mcmr_pkg::CfgAddrW-1:0] paddr,
  input  wire logic [mcmr_pkg::CfgDataW-1:0] pwdata,
  output      logic [mcmr_pkg::CfgDataW-1:0] prdata,
  output      logic                          pready
);

  mcmr_pkg::cfg_t cfg;
  mcmr_pkg::job_t new_job;
  mcmr_pkg::job_t head_job;
  logic           has_work;
  logic           job_valid;
  logic           job_pop;
  logic           out_valid;

  mcmr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mcmr_front u_front (
    .cfg_i      (cfg),
    .item_i     (in_item_i),
    .job_o      (new_job),
    .has_work_o (has_work)
  );

  mcmr_job_fifo #(
    .Depth (JobQueueDepth)
  ) u_job_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push && has_work),
    .data_i  (new_job),
    .full_o  (full),
    .pop_i   (job_pop),
    .valid_o (job_valid),
    .head_o  (head_job)
  );

  mcmr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (head_job),
    .job_pop_o   (job_pop),
    .pop         (pop && !empty),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== src/mcmr_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker
// Watches the router's ports and flags behavior that must never be seen.
// ----------------------------------------------------------------------------
`default_nettype none

module mcmr_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                empty,
  input wire logic                pop,
  input wire mcmr_pkg::out_item_t out_item_o,
  input wire logic                pready
);

  // A waiting result that is not taken stays, unchanged.
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed before its transfer");

  // Only engines A, B and C exist.
  a_engine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.target_engine != 2'd3)
    else $error("delivery names an unknown engine");

  // System messages never reach engine C.
  a_system_not_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.out_status[7:4] == mcmr_pkg::MsgSystem
      |-> out_item_o.target_engine != mcmr_pkg::EngC)
    else $error("system message delivered to engine C");

  // Control change never reaches engine C.
  a_cc_not_c: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.out_status[7:4] == mcmr_pkg::MsgCtrlChange
      |-> out_item_o.target_engine != mcmr_pkg::EngC)
    else $error("control change delivered to engine C");

  // The register port never inserts wait states.
  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind midi_channel_message_router mcmr_checker u_mcmr_checker (.*);

`default_nettype wire

// ===== verif/tb_midi_channel_message_router.sv =====
// ----------------------------------------------------------------------------
// MIDI channel message router testbench
// Drives short messages through the queue-style input and predicts every
// delivery from a local copy of the registers. Each popped delivery is
// compared field by field with the oldest prediction. Directed tests cover
// system messages, routing, layering, the allow masks and volume scaling.
// A back-pressure test and phases of random traffic over many register
// settings follow.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_midi_channel_message_router;

  import mcmr_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 4;
  localparam int HoldOffCycles = 300;

  logic                clk     = 1'b0;
  logic                rst_n   = 1'b0;
  logic                push    = 1'b0;
  logic                full;
  in_item_t            in_item = '0;
  logic                empty;
  logic                pop     = 1'b0;
  out_item_t           out_item;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [CfgAddrW-1:0] paddr   = '0;
  logic [CfgDataW-1:0] pwdata  = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  // Local copy of the register file.
  logic [RoutingW-1:0] route_cfg;
  logic [63:0]         remap_cfg;
  logic [63:0]         allow_cfg [2][2];
  logic [63:0]         vol_lo_cfg;
  logic [63:0]         vol_hi_cfg;

  out_item_t deliveries_due[$];

  int err_count       = 0;
  int msgs_sent       = 0;
  int deliveries_seen = 0;
  int reg_writes      = 0;
  int input_stalls    = 0;
  int quiet_cycles    = 0;
  int tx_gap_pct      = 0;
  int rx_gap_pct      = 0;
  int hold_left       = 0;
  int stall_left      = 0;
  bit hold_req        = 1'b0;

  midi_channel_message_router i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string what, int got, int want);
    err_count++;
    $display("mismatch: %s got %0h wanted %0h at %0t", what, got, want, $realtime);
  endtask

  // ---------------------------------------------------------------------------
  // Delivery predictor
  // ---------------------------------------------------------------------------

  function automatic bit engine_present(logic [1:0] eng);
    return route_cfg[48 + eng];
  endfunction

  function automatic bit cc_allowed(logic [1:0] eng, logic [6:0] cc);
    return allow_cfg[eng[0]][cc[6]][cc[5:0]];
  endfunction

  function automatic void add_delivery(logic [1:0] eng, logic [7:0] st, logic [7:0] d1,
                                       logic [7:0] d2);
    out_item_t d;
    d.target_engine = eng;
    d.out_status    = st;
    d.out_data_one  = d1;
    d.out_data_two  = d2;
    d.last_delivery = 1'b0;
    deliveries_due.push_back(d);
  endfunction

  function automatic void predict_routes(in_item_t m);
    logic [3:0] ch;
    logic [3:0] kind;
    logic [1:0] code;
    logic       layered;
    logic [7:0] st_out;
    logic [7:0] d2_out;
    logic [7:0] vol;
    logic [6:0] cc;
    int         scaled;
    int         base;
    out_item_t  tail;
    base = deliveries_due.size();
    ch   = m.status_byte[3:0];
    kind = m.status_byte[7:4];
    if (kind == MsgSystem) begin
      if (engine_present(EngA)) add_delivery(EngA, m.status_byte, m.data_one, m.data_two);
      if (engine_present(EngB)) add_delivery(EngB, m.status_byte, m.data_one, m.data_two);
    end else begin
      code    = route_cfg[2*ch +: 2];
      layered = route_cfg[32 + ch];
      st_out  = {kind, remap_cfg[4*ch +: 4]};
      if (kind == MsgCtrlChange) begin
        cc     = m.data_one[6:0];
        d2_out = m.data_two;
        if (cc == CcVolume) begin
          vol = ch[3] ? vol_hi_cfg[8*ch[2:0] +: 8] : vol_lo_cfg[8*ch[2:0] +: 8];
          // A volume byte of 128 or more is treated as unity gain.
          if (vol < 8'd128) begin
            scaled = (int'(m.data_two[6:0]) * int'(vol) + 64) >> 7;
            d2_out = scaled[7:0];
          end
        end
        if ((code == RouteA || code == RouteB) && engine_present(code - 2'd1) &&
            cc_allowed(code - 2'd1, cc)) begin
          add_delivery(code - 2'd1, st_out, m.data_one, d2_out);
        end
        if (layered) begin
          if (code != RouteA && engine_present(EngA) && cc_allowed(EngA, cc))
            add_delivery(EngA, st_out, m.data_one, d2_out);
          if (code != RouteB && engine_present(EngB) && cc_allowed(EngB, cc))
            add_delivery(EngB, st_out, m.data_one, d2_out);
        end
      end else if (layered && (kind == MsgNoteOn || kind == MsgNoteOff)) begin
        if (engine_present(EngA)) add_delivery(EngA, st_out, m.data_one, m.data_two);
        if (engine_present(EngB)) add_delivery(EngB, st_out, m.data_one, m.data_two);
      end else if (code != RouteNone && engine_present(code - 2'd1)) begin
        add_delivery(code - 2'd1, st_out, m.data_one, m.data_two);
      end
    end
    if (deliveries_due.size() > base) begin
      tail = deliveries_due.pop_back();
      tail.last_delivery = 1'b1;
      deliveries_due.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------

  function automatic logic [63:0] reg_model(logic [2:0] idx);
    case (idx)
      RegRouting:    return 64'(route_cfg);
      RegRemap:      return remap_cfg;
      RegAllowALow:  return allow_cfg[0][0];
      RegAllowAHigh: return allow_cfg[0][1];
      RegAllowBLow:  return allow_cfg[1][0];
      RegAllowBHigh: return allow_cfg[1][1];
      RegVolLow:     return vol_lo_cfg;
      default:       return vol_hi_cfg;
    endcase
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      RegRouting:    route_cfg = val[RoutingW-1:0];
      RegRemap:      remap_cfg = val;
      RegAllowALow:  allow_cfg[0][0] = val;
      RegAllowAHigh: allow_cfg[0][1] = val;
      RegAllowBLow:  allow_cfg[1][0] = val;
      RegAllowBHigh: allow_cfg[1][1] = val;
      RegVolLow:     vol_lo_cfg = val;
      default:       vol_hi_cfg = val;
    endcase
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_reg(logic [2:0] idx);
    logic [63:0] rd;
    logic [63:0] mask;
    logic [63:0] want;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 3'b000};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd   = prdata;
    want = reg_model(idx);
    // Routing is narrower than the data bus; only its own bits are compared.
    mask = (idx == RegRouting) ? {{(64-RoutingW){1'b0}}, {RoutingW{1'b1}}} : '1;
    if ((rd & mask) !== (want & mask)) begin
      report_mismatch($sformatf("register %0d readback", idx), int'(rd[31:0]),
                      int'(want[31:0]));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Message side
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_msg(logic [7:0] st, logic [7:0] d1, logic [7:0] d2);
    in_item_t m;
    m.status_byte = st;
    m.data_one    = d1;
    m.data_two    = d2;
    if (tx_gap_pct > 0 && $urandom_range(0, 99) < tx_gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    push    <= 1'b1;
    in_item <= m;
    do @(posedge clk); while (full);
    predict_routes(m);
    msgs_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (deliveries_due.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  function automatic in_item_t rand_msg();
    in_item_t   m;
    logic [3:0] ch;
    logic [3:0] kind;
    int         k;
    k          = $urandom_range(0, 99);
    ch         = 4'($urandom_range(0, 15));
    kind       = 4'($urandom_range(0, 14));
    m.data_one = 8'($urandom_range(0, 255));
    m.data_two = 8'($urandom_range(0, 255));
    if (k < 35) begin
      m.status_byte = {MsgCtrlChange, ch};
      if ($urandom_range(0, 2) == 0) m.data_one = {m.data_one[7], CcVolume};
    end else if (k < 60) begin
      m.status_byte = {($urandom_range(0, 1) != 0) ? MsgNoteOn : MsgNoteOff, ch};
    end else if (k < 75) begin
      m.status_byte = {kind, ch};
    end else if (k < 85) begin
      m.status_byte = {MsgSystem, ch};
    end else begin
      m.status_byte = 8'($urandom_range(0, 255));
    end
    return m;
  endfunction

  function automatic logic [63:0] pick_reg_value(int phase, logic [2:0] idx);
    logic [63:0] v;
    logic [2:0]  pres;
    int          i;
    v = {$urandom, $urandom};
    if (phase == 1) return '1;
    if (phase == 2) return '0;
    case (idx)
      RegRouting: begin
        pres = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'b111;
        v    = {13'd0, pres, v[47:0]};
      end
      RegAllowALow, RegAllowAHigh, RegAllowBLow, RegAllowBHigh: begin
        case ($urandom_range(0, 4))
          0, 1:    v = '1;
          2:       v = '0;
          default: v = v;
        endcase
      end
      RegVolLow, RegVolHigh: begin
        for (i = 0; i < 8; i++) begin
          case ($urandom_range(0, 5))
            0:       v[8*i +: 8] = 8'h00;
            1:       v[8*i +: 8] = 8'h7F;
            2:       v[8*i +: 8] = 8'h80;
            3:       v[8*i +: 8] = 8'hFF;
            default: v[8*i +: 8] = 8'($urandom_range(0, 255));
          endcase
        end
      end
      default: v = v;
    endcase
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HoldOffCycles - 1;
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else if (rx_gap_pct > 0 && $urandom_range(0, 99) < rx_gap_pct) begin
      stall_left = $urandom_range(1, 7) - 1;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_deliveries
    out_item_t want;
    if (rst_n && pop && !empty) begin
      deliveries_seen++;
      if (deliveries_due.size() == 0) begin
        report_mismatch("delivery with nothing pending, status",
                        int'(out_item.out_status), 0);
      end else begin
        want = deliveries_due.pop_front();
        if (out_item.target_engine !== want.target_engine)
          report_mismatch("target_engine", int'(out_item.target_engine),
                          int'(want.target_engine));
        if (out_item.out_status !== want.out_status)
          report_mismatch("out_status", int'(out_item.out_status), int'(want.out_status));
        if (out_item.out_data_one !== want.out_data_one)
          report_mismatch("out_data_one", int'(out_item.out_data_one),
                          int'(want.out_data_one));
        if (out_item.out_data_two !== want.out_data_two)
          report_mismatch("out_data_two", int'(out_item.out_data_two),
                          int'(want.out_data_two));
        if (out_item.last_delivery !== want.last_delivery)
          report_mismatch("last_delivery", int'(out_item.last_delivery),
                          int'(want.last_delivery));
      end
    end
  end

  always @(posedge clk) begin
    if (push && full) input_stalls++;
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // With no engine present after reset, nothing may come out.
  task automatic test_reset_defaults();
    int i;
    for (i = 0; i < 8; i++) check_reg(3'(i));
    send_msg(8'hFF, 8'h00, 8'hFF);
    send_msg(8'h90, 8'h3C, 8'h7F);
    send_msg(8'hB0, 8'h07, 8'h40);
    wait_drained();
  endtask

  task automatic test_register_access();
    int i;
    for (i = 0; i < 8; i++) write_reg(3'(i), {$urandom, $urandom});
    for (i = 0; i < 8; i++) check_reg(3'(i));
  endtask

  task automatic test_system_messages();
    write_reg(RegRouting, 64'h0007_0000_0000_0000);
    send_msg(8'hF0, 8'h00, 8'h00);
    send_msg(8'hFF, 8'hFF, 8'hFF);
    wait_drained();
    // Only B and C present: B alone receives, C never gets system messages.
    write_reg(RegRouting, 64'h0006_0000_0000_0000);
    send_msg(8'hF8, 8'h7F, 8'h80);
    wait_drained();
    write_reg(RegRouting, 64'h0004_0000_0000_0000);
    send_msg(8'hF7, 8'h55, 8'hAA);
    wait_drained();
  endtask

  // Channel 0 to A, 1 to B, 2 to C, 3 unrouted, 4 layered on A, 15 layered on C.
  task automatic test_channel_routing();
    write_reg(RegRouting, 64'h0007_8010_C000_0139);
    write_reg(RegRemap, 64'h0123_4567_89AB_CDEF);
    send_msg(8'h90, 8'h3C, 8'h7F);
    send_msg(8'h81, 8'h00, 8'h00);
    send_msg(8'hC2, 8'h05, 8'h00);
    send_msg(8'h93, 8'h3C, 8'h40);
    send_msg(8'h94, 8'h3C, 8'h64);
    send_msg(8'h8F, 8'h3C, 8'h00);
    send_msg(8'hE2, 8'h00, 8'h40);
    send_msg(8'h42, 8'h80, 8'hFF);
    wait_drained();
  endtask

  task automatic test_control_change();
    write_reg(RegVolLow, 64'h8080_8040_80FF_7F00);
    write_reg(RegVolHigh, 64'hFF80_8080_8080_8001);
    write_reg(RegAllowAHigh, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(RegAllowBLow, 64'hFFFF_FFFF_FFFF_FFFD);
    send_msg(8'hB0, 8'h07, 8'h7F);
    send_msg(8'hB1, 8'h07, 8'hFF);
    // Controller number wraps modulo 128 but the byte itself passes through.
    send_msg(8'hB1, 8'h87, 8'h40);
    send_msg(8'hB4, 8'h07, 8'h7F);
    send_msg(8'hB4, 8'h7F, 8'h55);
    send_msg(8'hBF, 8'h07, 8'h33);
    send_msg(8'hB0, 8'h01, 8'h00);
    send_msg(8'hB1, 8'h01, 8'h7F);
    send_msg(8'hB0, 8'h00, 8'hFF);
    wait_drained();
  endtask

  // Every channel layered on A: each control change makes two deliveries.
  task automatic test_back_pressure();
    int       i;
    in_item_t m;
    write_reg(RegRouting, 64'h0007_FFFF_5555_5555);
    write_reg(RegAllowALow, '1);
    write_reg(RegAllowAHigh, '1);
    write_reg(RegAllowBLow, '1);
    write_reg(RegAllowBHigh, '1);
    tx_gap_pct = 0;
    rx_gap_pct = 0;
    hold_req   = 1'b1;
    for (i = 0; i < 40; i++) begin
      m = rand_msg();
      send_msg({MsgCtrlChange, m.status_byte[3:0]}, m.data_one, m.data_two);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int       phase;
    int       i;
    int       count;
    in_item_t m;
    for (phase = 0; phase < 9; phase++) begin
      for (i = 0; i < 8; i++) write_reg(3'(i), pick_reg_value(phase, 3'(i)));
      // The final phase runs at full rate on both sides.
      tx_gap_pct = (phase == 8) ? 0 : $urandom_range(0, 30);
      rx_gap_pct = (phase == 8) ? 0 : $urandom_range(0, 40);
      count      = (phase == 2) ? 60 : 215;
      for (i = 0; i < count; i++) begin
        m = rand_msg();
        send_msg(m.status_byte, m.data_one, m.data_two);
      end
      wait_drained();
    end
  endtask

  initial begin
    route_cfg       = RoutingReset;
    remap_cfg       = RemapReset;
    allow_cfg[0][0] = AllowReset;
    allow_cfg[0][1] = AllowReset;
    allow_cfg[1][0] = AllowReset;
    allow_cfg[1][1] = AllowReset;
    vol_lo_cfg      = VolReset;
    vol_hi_cfg      = VolReset;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    tx_gap_pct = 20;
    rx_gap_pct = 20;
    test_reset_defaults();
    test_register_access();
    test_system_messages();
    test_channel_routing();
    test_control_change();
    test_back_pressure();
    test_random_traffic();
    $display("summary: %0d messages sent, %0d deliveries checked, %0d register writes",
             msgs_sent, deliveries_seen, reg_writes);
    $display("summary: input held off for %0d cycles under receiver back-pressure",
             input_stalls);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
